/* sv/stereo_soft_saturate_gate_unit_assert.svh */
// Assertion macros for the checker file.
`ifndef STEREO_SOFT_SATURATE_GATE_UNIT_ASSERT_SVH
`define STEREO_SOFT_SATURATE_GATE_UNIT_ASSERT_SVH

// Clocked assertion, muted while reset is asserted.
`define SSSG_ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sssg assertion failed");

// Clocked assertion that also holds during reset.
`define SSSG_ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sssg assertion failed");

`endif

/* sv/sssg_pkg.sv */
`timescale 1ns / 1ps
package sssg_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SAT,
    ST_NUM,
    ST_DIV,
    ST_SATD,
    ST_GATE,
    ST_FIN
  } state_t;

  localparam logic [0:0]  CFG_ENABLED = 1'b0;
  localparam logic [0:0]  CFG_GAIN    = 1'b1;
  localparam logic [11:0] GAIN_RESET  = 12'd768;
  localparam logic [8:0]  GATE_FULL   = 9'd256;
  localparam logic [12:0] SAT_KNEE    = 13'd80;
  localparam logic [10:0] SAT_SOFT    = 11'd47;
  localparam logic [12:0] CENTER      = 13'd128;
  localparam logic [8:0]  OUT_MAX     = 9'd255;

endpackage

/* sv/stereo_soft_saturate_gate_unit.sv */
`timescale 1ns / 1ps
// Per channel, left then right: ST_MUL, ST_SAT, ST_NUM, ST_DIV, ST_SATD
// (the last three only above the knee), ST_GATE, ST_FIN; a disabled word goes
// straight to ST_FIN. New words are taken only in ST_IDLE. A single shared
// multiplier and a 6-step restoring divider are sequenced per channel.
// A held output word stalls the last step until the receiver takes it.
// Reset (rst_n low, synchronous): enabled=0, gain=768, gate level 0, no result.
module stereo_soft_saturate_gate_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] left_sample, [31:16] right_sample
  input  logic        in_tuser,   // [0] voices_active
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] left_out, [15:8] right_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import sssg_pkg::*;

  state_t state_r, state_nxt;

  logic        enabled_r;
  logic [11:0] gain_r;
  logic [8:0]  gate_r, gate_nxt;
  logic [15:0] left_r, right_r;
  logic        ch_r, ch_nxt;
  logic signed [29:0] prod_r, prod_nxt;
  logic        neg_r, neg_nxt;
  logic [10:0] d_r, d_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [10:0] den_r, den_nxt;
  logic [2:0]  k_r, k_nxt;
  logic [5:0]  q_r, q_nxt;
  logic [7:0]  cent_r, cent_nxt;
  logic [7:0]  res_l_r, res_l_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_data_r, out_data_nxt;

  logic signed [16:0] op_a;
  logic signed [12:0] op_b;
  logic signed [29:0] mult;
  logic signed [12:0] x;
  logic [12:0] a_mag;
  logic [17:0] trial;
  logic [12:0] sat;
  logic [8:0]  vout;
  logic [7:0]  vclamp;
  logic        in_acc;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // shared multiplier
  assign mult = op_a * op_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      gain_r    <= GAIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        {1'b0, CFG_ENABLED}: enabled_r <= cfg_data[0];
        {1'b0, CFG_GAIN}:    gain_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gate_r      <= '0;
      out_valid_r <= 1'b0;
      ch_r        <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      gate_r      <= gate_nxt;
      out_valid_r <= out_valid_nxt;
      ch_r        <= ch_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      left_r  <= in_tdata[15:0];
      right_r <= in_tdata[31:16];
    end
    prod_r     <= prod_nxt;
    neg_r      <= neg_nxt;
    d_r        <= d_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    q_r        <= q_nxt;
    cent_r     <= cent_nxt;
    res_l_r    <= res_l_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    gate_nxt      = gate_r;
    ch_nxt        = ch_r;
    k_nxt         = k_r;
    prod_nxt      = prod_r;
    neg_nxt       = neg_r;
    d_nxt         = d_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    q_nxt         = q_r;
    cent_nxt      = cent_r;
    res_l_nxt     = res_l_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    op_a   = '0;
    op_b   = '0;
    x      = prod_r[28:16];  // floor shift by 16
    a_mag  = x[12] ? 13'(-x) : 13'(x);
    trial  = {1'b0, rem_r} - ({7'd0, den_r} << k_r);
    sat    = SAT_KNEE + {7'd0, q_r};
    vout   = prod_r[16:8];
    vclamp = (vout > OUT_MAX) ? OUT_MAX[7:0] : vout[7:0];

    case (state_r)
      ST_MUL: begin
        op_a = ch_r ? {right_r[15], right_r} : {left_r[15], left_r};
        op_b = {1'b0, gain_r};
      end
      ST_NUM: begin
        op_a = {6'd0, d_r};
        op_b = {2'd0, SAT_SOFT};
      end
      ST_GATE: begin
        op_a = {9'd0, cent_r};
        op_b = {4'd0, gate_r};
      end
      default: ;
    endcase

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ch_nxt = 1'b0;
          if (!enabled_r) begin
            // silent word: both halves come out as zero from the last step
            gate_nxt  = '0;
            res_l_nxt = '0;
            prod_nxt  = '0;
            ch_nxt    = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            if (in_tuser) begin
              if (gate_r < GATE_FULL) gate_nxt = gate_r + 9'd1;
            end else begin
              if (gate_r != 9'd0) gate_nxt = gate_r - 9'd1;
            end
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        prod_nxt  = mult;
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        neg_nxt = x[12];
        if (a_mag > SAT_KNEE) begin
          d_nxt     = 11'(a_mag - SAT_KNEE);
          state_nxt = ST_NUM;
        end else begin
          cent_nxt  = 8'(CENTER + x);
          state_nxt = ST_GATE;
        end
      end
      ST_NUM: begin
        rem_nxt   = mult[16:0];
        den_nxt   = d_r + SAT_SOFT;
        k_nxt     = 3'd5;
        q_nxt     = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // one restoring step per cycle, quotient below 64
        if (!trial[17]) begin
          rem_nxt     = trial[16:0];
          q_nxt[k_r]  = 1'b1;
        end
        if (k_r == 3'd0) state_nxt = ST_SATD;
        else k_nxt = k_r - 3'd1;
      end
      ST_SATD: begin
        cent_nxt  = neg_r ? 8'(CENTER - sat) : 8'(CENTER + sat);
        state_nxt = ST_GATE;
      end
      ST_GATE: begin
        // result taken on the next cycle from prod_r
        prod_nxt  = mult;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!ch_r) begin
          res_l_nxt = vclamp;
          ch_nxt    = 1'b1;
          state_nxt = ST_MUL;
        end else if (!out_valid_r || out_tready) begin
          // hold here until the output word is free
          out_valid_nxt = 1'b1;
          out_data_nxt  = {vclamp, res_l_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* sv/sssg_check.sv */
`timescale 1ns / 1ps
`include "stereo_soft_saturate_gate_unit_assert.svh"
module sssg_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  `SSSG_ASSERT_ALL(a_reset_no_out, clk, !rst_n |=> !out_tvalid)
  `SSSG_ASSERT_RST(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `SSSG_ASSERT_RST(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready |=> !in_tready)
  `SSSG_ASSERT_RST(a_no_out_at_accept, clk, rst_n,
                   in_tvalid && in_tready |=> !(out_tvalid && $rose(out_tvalid)))
endmodule

bind stereo_soft_saturate_gate_unit sssg_check u_sssg_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* sim/stereo_soft_saturate_gate_unit_tb.sv */
`timescale 1ns / 1ps
module stereo_soft_saturate_gate_unit_tb;

  localparam logic [1:0] IDX_ENABLED = {1'b0, sssg_pkg::CFG_ENABLED};
  localparam logic [1:0] IDX_GAIN    = {1'b0, sssg_pkg::CFG_GAIN};
  localparam logic [1:0] IDX_SPARE2  = 2'd2;
  localparam logic [1:0] IDX_SPARE3  = 2'd3;

  localparam int KNEE      = int'(sssg_pkg::SAT_KNEE);
  localparam int SOFT      = int'(sssg_pkg::SAT_SOFT);
  localparam int MID       = int'(sssg_pkg::CENTER);
  localparam int TOP       = int'(sssg_pkg::OUT_MAX);
  localparam int GATE_TOP  = int'(sssg_pkg::GATE_FULL);
  localparam int DRAIN_CYC = 48;
  localparam int LIMIT     = 400000;

  typedef struct packed {
    logic [7:0] right;
    logic [7:0] left;
  } pair_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  idx;
    logic [11:0] val;
    logic [15:0] left;
    logic [15:0] right;
    logic        act;
    logic        typed;
    logic [7:0]  exp_l;
    logic [7:0]  exp_r;
  } row_t;

  localparam int NROWS = 23;
  // kind, reg index, reg data, left, right, active, typed, expected left/right
  localparam row_t DIR_ROWS [NROWS] = '{
    // disabled after reset: silent whatever comes in
    '{ROW_ITEM, 2'd0, 12'd0, 16'h7FFF, 16'h8000, 1'b1, 1'b1, 8'd0, 8'd0},
    '{ROW_ITEM, 2'd0, 12'd0, 16'h8000, 16'h7FFF, 1'b0, 1'b1, 8'd0, 8'd0},
    // writes to unused indexes are dropped
    '{ROW_CFG,  IDX_SPARE2, 12'hFFF, 16'h0, 16'h0, 1'b0, 1'b0, 8'd0, 8'd0},
    '{ROW_CFG,  IDX_SPARE3, 12'h001, 16'h0, 16'h0, 1'b0, 1'b0, 8'd0, 8'd0},
    '{ROW_ITEM, 2'd0, 12'd0, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 8'd0, 8'd0},
    '{ROW_CFG,  IDX_ENABLED, 12'h001, 16'h0, 16'h0, 1'b0, 1'b0, 8'd0, 8'd0},
    '{ROW_ITEM, 2'd0, 12'd0, 16'h7FFF, 16'h8000, 1'b1, 1'b0, 8'd0, 8'd0},
    '{ROW_ITEM, 2'd0, 12'd0, 16'h8000, 16'h7FFF, 1'b1, 1'b0, 8'd0, 8'd0},
    // small negative scales to -1 (floor), not 0
    '{ROW_ITEM, 2'd0, 12'd0, 16'hFFFF, 16'h0001, 1'b1, 1'b0, 8'd0, 8'd0},
    // just above the knee on both signs
    '{ROW_ITEM, 2'd0, 12'd0, 16'd6912, -16'sd6912, 1'b1, 1'b0, 8'd0, 8'd0},
    '{ROW_ITEM, 2'd0, 12'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'd0, 8'd0},
    '{ROW_CFG,  IDX_GAIN, 12'h000, 16'h0, 16'h0, 1'b0, 1'b0, 8'd0, 8'd0},
    '{ROW_ITEM, 2'd0, 12'd0, 16'h7FFF, 16'h8000, 1'b1, 1'b0, 8'd0, 8'd0},
    '{ROW_CFG,  IDX_GAIN, 12'hFFF, 16'h0, 16'h0, 1'b0, 1'b0, 8'd0, 8'd0},
    '{ROW_ITEM, 2'd0, 12'd0, 16'h7FFF, 16'h8000, 1'b1, 1'b0, 8'd0, 8'd0},
    '{ROW_ITEM, 2'd0, 12'd0, 16'h8000, 16'h7FFF, 1'b1, 1'b0, 8'd0, 8'd0},
    '{ROW_ITEM, 2'd0, 12'd0, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 8'd0, 8'd0},
    // disable mid-run clears the gate
    '{ROW_CFG,  IDX_ENABLED, 12'h000, 16'h0, 16'h0, 1'b0, 1'b0, 8'd0, 8'd0},
    '{ROW_ITEM, 2'd0, 12'd0, 16'd1234, -16'sd1234, 1'b1, 1'b1, 8'd0, 8'd0},
    '{ROW_CFG,  IDX_ENABLED, 12'h001, 16'h0, 16'h0, 1'b0, 1'b0, 8'd0, 8'd0},
    // idle with gate already closed stays at zero
    '{ROW_ITEM, 2'd0, 12'd0, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 8'd0, 8'd0},
    '{ROW_ITEM, 2'd0, 12'd0, 16'd100, -16'sd100, 1'b1, 1'b0, 8'd0, 8'd0},
    '{ROW_ITEM, 2'd0, 12'd0, 16'h4000, 16'hC000, 1'b1, 1'b0, 8'd0, 8'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  // predictor state
  bit          bank_on;
  logic [11:0] drive_gain;
  int          gate_lvl;

  pair_t pending_pairs[$];
  int    pairs_sent = 0;
  int    pairs_seen = 0;
  int    bad_cnt = 0;
  int    cyc = 0;

  stereo_soft_saturate_gate_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] shape_channel(logic signed [15:0] s);
    longint prod;
    int     scaled, mag, d, v;
    bit     neg;
    prod   = longint'(s) * longint'(drive_gain);
    scaled = int'(prod >>> 16);
    neg    = scaled < 0;
    mag    = neg ? -scaled : scaled;
    if (mag > KNEE) begin
      d   = mag - KNEE;
      mag = KNEE + (d * SOFT) / (d + SOFT);
    end
    v = ((MID + (neg ? -mag : mag)) * gate_lvl) / 256;
    if (v < 0) v = 0;
    if (v > TOP) v = TOP;
    return v[7:0];
  endfunction

  function automatic pair_t advance_gate_pair(logic [15:0] l, logic [15:0] r, logic act);
    pair_t p;
    p = '0;
    if (!bank_on) begin
      gate_lvl = 0;
      return p;
    end
    if (act) begin
      if (gate_lvl < GATE_TOP) gate_lvl++;
    end else if (gate_lvl > 0) begin
      gate_lvl--;
    end
    p.left  = shape_channel(l);
    p.right = shape_channel(r);
    return p;
  endfunction

  function automatic logic [15:0] rand_sample();
    logic [15:0] m;
    case ($urandom_range(0, 4))
      0: begin
        case ($urandom_range(0, 3))
          0: m = 16'h7FFF;
          1: m = 16'h8000;
          2: m = 16'h0000;
          default: m = 16'hFFFF;
        endcase
      end
      1: begin
        m = 16'($urandom_range(0, 2047));
        if ($urandom_range(0, 1) == 1) m = -m;
      end
      2: begin
        m = 16'($urandom_range(0, 12000));
        if ($urandom_range(0, 1) == 1) m = -m;
      end
      default: m = 16'($urandom);
    endcase
    return m;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    bad_cnt++;
    if (bad_cnt <= 30)
      $display("mismatch at word %0d: %s got %0d expected %0d", pairs_seen, what, got, want);
  endtask

  task automatic send_pair(logic [15:0] l, logic [15:0] r, logic act, bit typed,
                           pair_t typed_val);
    pair_t p;
    in_tdata  <= {r, l};
    in_tuser  <= act;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    p = advance_gate_pair(l, r, act);
    if (typed) p = typed_val;
    pending_pairs = {pending_pairs, p};
    pairs_sent++;
    // words 600..849 go back to back
    if (!(pairs_sent >= 600 && pairs_sent < 850) && $urandom_range(0, 99) < 16) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] val);
    in_tvalid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == IDX_ENABLED) bank_on = val[0];
    else if (idx == IDX_GAIN) drive_gain = val;
  endtask

  // result checker
  always @(posedge clk) begin
    pair_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      pairs_seen++;
      if (pending_pairs.size() == 0) begin
        report_mismatch("word with nothing pending", int'(got), 0);
      end else begin
        want = pending_pairs.pop_front();
        if (got.left != want.left) report_mismatch("left_out", got.left, want.left);
        if (got.right != want.right) report_mismatch("right_out", got.right, want.right);
      end
    end
  end

  // receiver: random stalls, one long hold-off, one stretch with no stalls
  initial begin
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held && pairs_sent >= 300) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (500) @(posedge clk);
      end
      out_tready <= (pairs_seen >= 600 && pairs_seen < 850) || $urandom_range(0, 99) >= 16;
    end
  end

  initial begin
    while (cyc < LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("stereo_soft_saturate_gate_unit_tb NOT OK");
    $finish;
  end

  initial begin
    row_t        row;
    pair_t       typed_val;
    logic [11:0] g;
    bit          en, run_on;
    int          n_items, run_left;
    bank_on    = 1'b0;
    drive_gain = sssg_pkg::GAIN_RESET;
    gate_lvl   = 0;
    run_left   = 0;
    run_on     = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NROWS; i++) begin
      row = DIR_ROWS[i];
      if (row.kind == ROW_CFG) begin
        write_reg(row.idx, row.val);
      end else begin
        typed_val.left  = row.exp_l;
        typed_val.right = row.exp_r;
        send_pair(row.left, row.right, row.act, row.typed, typed_val);
      end
    end

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: g = 12'hFFF;
        1: g = 12'h000;
        2: g = 12'd256;
        3: g = sssg_pkg::GAIN_RESET;
        default: g = 12'($urandom_range(0, 4095));
      endcase
      en = (ph != 5);
      write_reg(IDX_GAIN, g);
      write_reg(IDX_ENABLED, {11'd0, en});
      n_items = en ? 165 : 30;
      for (int k = 0; k < n_items; k++) begin
        // long active runs open the gate fully, idle runs let it decay
        if (run_left == 0) begin
          run_on   = $urandom_range(0, 99) < 75;
          run_left = run_on ? $urandom_range(20, 300) : $urandom_range(1, 60);
        end
        run_left--;
        send_pair(rand_sample(), rand_sample(), run_on ^ ($urandom_range(0, 99) < 5),
                  1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (bad_cnt == 0)
      $display("stereo_soft_saturate_gate_unit_tb OK");
    else
      $display("stereo_soft_saturate_gate_unit_tb NOT OK");
    $finish;
  end

endmodule
